FILE: hw/rtl/relative_page_extent_map_assert.svh
// ----------------------------------------------------------------------------
// relative page extent map assertion macros
// shared property forms for the checker, clocked on clk, reset on rst_n
// ----------------------------------------------------------------------------
`ifndef RELATIVE_PAGE_EXTENT_MAP_ASSERT_SVH
`define RELATIVE_PAGE_EXTENT_MAP_ASSERT_SVH

// same-cycle implication, off during reset
`define RPEM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("relative page extent map check failed");

// next-cycle implication, off during reset
`define RPEM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("relative page extent map check failed");

// next-cycle implication that also holds through reset
`define RPEM_ASSERT_NEXT_ANY(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error("relative page extent map check failed");

`endif

FILE: hw/rtl/rpem_pkg.sv
// ----------------------------------------------------------------------------
// rpem_pkg
// types and codes shared by the relative page extent map modules
// ----------------------------------------------------------------------------
package rpem_pkg;

  localparam int PAGE_W = 64;

  localparam logic OP_ASSIGN    = 1'b0;
  localparam logic OP_TRANSLATE = 1'b1;

  typedef enum logic [1:0] {
    STS_OK        = 2'd0,
    STS_NOT_FOUND = 2'd1,
    STS_FULL      = 2'd2,
    STS_ORDER     = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ASN_CHECK,
    ST_ASN_ADD,
    ST_SRCH,
    ST_CMP,
    ST_RESULT
  } state_t;

  typedef struct packed {
    logic load;
    logic asn_reject;
    logic asn_new;
    logic asn_diff;
    logic asn_add;
    logic srch_cmp;
    logic srch_done;
    logic out_load;
  } dp_cmd_t;

  typedef struct packed {
    logic asn_first;
    logic asn_err;
    logic srch_more;
  } dp_stat_t;

endpackage

FILE: hw/rtl/relative_page_extent_map.sv
// ----------------------------------------------------------------------------
// relative_page_extent_map
// maps relative page numbers to storage pages through a table of extents
// ----------------------------------------------------------------------------
// One request at a time. An assign passes through a check state and then the
// result state when it opens a new extent or fails, and through the check, add
// and result states when it continues the current extent. A translate runs a
// binary search over the extent table, each probe a search state and a compare
// state because of the registered read of the extent memory, with at most
// ceil(log2(entries + 1)) probes. The result waits in an output register, so
// the next request is taken while an earlier result is pending; a request
// whose result finds that register still full holds in its result state until
// out_ready takes the earlier result.
module relative_page_extent_map import rpem_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              in_operation,
  input  logic [PAGE_W-1:0] in_storage_page,
  input  logic              in_first_in_step,
  input  logic [PAGE_W-1:0] in_query_rel_page,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [PAGE_W-1:0] out_page_number,
  output logic [1:0]        out_status
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rpem_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .stat         (stat),
    .cmd          (cmd)
  );

  rpem_dp #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_storage_page   (in_storage_page),
    .in_first_in_step  (in_first_in_step),
    .in_query_rel_page (in_query_rel_page),
    .out_page_number   (out_page_number),
    .out_status        (out_status)
  );

endmodule

FILE: hw/rtl/rpem_ram.sv
// ----------------------------------------------------------------------------
// rpem_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module rpem_ram #(
  parameter int WIDTH = 128,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

FILE: hw/rtl/rpem_ctrl.sv
// ----------------------------------------------------------------------------
// rpem_ctrl
// sequencer for assign and translate requests and the result handshake
// ----------------------------------------------------------------------------
module rpem_ctrl import rpem_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  input  logic     in_operation,
  output logic     in_ready,
  output logic     out_valid,
  input  logic     out_ready,
  input  dp_stat_t stat,
  output dp_cmd_t  cmd
);

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (in_operation)
            OP_ASSIGN:    state_nxt = ST_ASN_CHECK;
            OP_TRANSLATE: state_nxt = ST_SRCH;
          endcase
        end
      end
      ST_ASN_CHECK: begin
        if (stat.asn_err || stat.asn_first) begin
          state_nxt = ST_RESULT;
        end else begin
          state_nxt = ST_ASN_ADD;
        end
      end
      ST_ASN_ADD: state_nxt = ST_RESULT;
      ST_SRCH: begin
        if (stat.srch_more) begin
          state_nxt = ST_CMP;
        end else begin
          state_nxt = ST_RESULT;
        end
      end
      ST_CMP: state_nxt = ST_SRCH;
      ST_RESULT: begin
        if (!out_valid_r || out_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      ST_ASN_CHECK: begin
        priority if (stat.asn_err) begin
          cmd.asn_reject = 1'b1;
        end else if (stat.asn_first) begin
          cmd.asn_new = 1'b1;
        end else begin
          cmd.asn_diff = 1'b1;
        end
      end
      ST_ASN_ADD: cmd.asn_add = 1'b1;
      ST_SRCH:    cmd.srch_done = !stat.srch_more;
      ST_CMP:     cmd.srch_cmp = 1'b1;
      ST_RESULT:  cmd.out_load = !out_valid_r || out_ready;
      default: begin
        cmd      = '0;
        in_ready = 1'b0;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    priority if (cmd.out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: hw/rtl/rpem_dp.sv
// ----------------------------------------------------------------------------
// rpem_dp
// extent table, cursor and maximum registers, binary search and result
// ----------------------------------------------------------------------------
module rpem_dp import rpem_pkg::*; #(
  parameter int TABLE_DEPTH = 1024
) (
  input  logic              clk,
  input  logic              rst_n,
  input  dp_cmd_t           cmd,
  output dp_stat_t          stat,
  input  logic [PAGE_W-1:0] in_storage_page,
  input  logic              in_first_in_step,
  input  logic [PAGE_W-1:0] in_query_rel_page,
  output logic [PAGE_W-1:0] out_page_number,
  output logic [1:0]        out_status
);

  localparam int IW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);

  logic [PAGE_W-1:0] sp_r, sp_nxt;
  logic              first_r, first_nxt;
  logic [PAGE_W-1:0] q_r, q_nxt;
  logic [CW-1:0]     lo_r, lo_nxt;
  logic [CW-1:0]     hi_r, hi_nxt;
  logic [CW-1:0]     cnt_r, cnt_nxt;
  logic [PAGE_W-1:0] last_r, last_nxt;
  logic [PAGE_W-1:0] cursor_r, cursor_nxt;
  logic [PAGE_W-1:0] max_r, max_nxt;
  logic [PAGE_W-1:0] diff_r, diff_nxt;
  logic [PAGE_W-1:0] cand_r, cand_nxt;
  logic [PAGE_W-1:0] res_page_r, res_page_nxt;
  status_t           res_sts_r, res_sts_nxt;
  logic [PAGE_W-1:0] out_page_r, out_page_nxt;
  status_t           out_sts_r, out_sts_nxt;

  logic [CW-1:0]         mid;
  logic [PAGE_W-1:0]     max_inc;
  logic [PAGE_W-1:0]     add_sum;
  logic [PAGE_W-1:0]     found_sum;
  logic [2*PAGE_W-1:0]   rdata;
  logic [PAGE_W-1:0]     rd_rel;
  logic [PAGE_W-1:0]     rd_sto;
  logic                  full;
  logic                  order_err;
  status_t               asn_code;

  assign mid       = lo_r + ((hi_r - lo_r) >> 1);
  assign max_inc   = max_r + PAGE_W'(1);
  assign add_sum   = cursor_r + diff_r;
  assign found_sum = cand_r + diff_r;
  assign rd_rel    = rdata[2*PAGE_W-1:PAGE_W];
  assign rd_sto    = rdata[PAGE_W-1:0];

  assign full      = (cnt_r == CW'(TABLE_DEPTH));
  assign order_err = first_r ? ((sp_r <= last_r) || (max_r == '1)) : (sp_r < last_r);
  assign asn_code  = (first_r && full) ? STS_FULL : STS_ORDER;

  assign stat.asn_first = first_r;
  assign stat.asn_err   = (first_r && full) || order_err;
  assign stat.srch_more = (lo_r < hi_r);

  rpem_ram #(
    .WIDTH (2 * PAGE_W),
    .DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk   (clk),
    .we    (cmd.asn_new),
    .waddr (cnt_r[IW-1:0]),
    .wdata ({max_inc, sp_r}),
    .raddr (mid[IW-1:0]),
    .rdata (rdata)
  );

  always_comb begin
    sp_nxt       = sp_r;
    first_nxt    = first_r;
    q_nxt        = q_r;
    lo_nxt       = lo_r;
    hi_nxt       = hi_r;
    cnt_nxt      = cnt_r;
    last_nxt     = last_r;
    cursor_nxt   = cursor_r;
    max_nxt      = max_r;
    diff_nxt     = diff_r;
    cand_nxt     = cand_r;
    res_page_nxt = res_page_r;
    res_sts_nxt  = res_sts_r;
    out_page_nxt = out_page_r;
    out_sts_nxt  = out_sts_r;

    if (cmd.load) begin
      sp_nxt    = in_storage_page;
      first_nxt = in_first_in_step;
      q_nxt     = in_query_rel_page;
      lo_nxt    = '0;
      hi_nxt    = cnt_r;
    end
    if (cmd.asn_reject) begin
      res_page_nxt = '0;
      res_sts_nxt  = asn_code;
    end
    if (cmd.asn_new) begin
      cnt_nxt      = cnt_r + CW'(1);
      last_nxt     = sp_r;
      cursor_nxt   = max_inc;
      max_nxt      = max_inc;
      res_page_nxt = max_inc;
      res_sts_nxt  = STS_OK;
    end
    if (cmd.asn_diff) begin
      diff_nxt = sp_r - last_r;
    end
    if (cmd.asn_add) begin
      res_page_nxt = add_sum;
      res_sts_nxt  = STS_OK;
      if (add_sum > max_r) begin
        max_nxt = add_sum;
      end
    end
    if (cmd.srch_cmp) begin
      if (rd_rel <= q_r) begin
        lo_nxt   = mid + CW'(1);
        cand_nxt = rd_sto;
        diff_nxt = q_r - rd_rel;
      end else begin
        hi_nxt = mid;
      end
    end
    if (cmd.srch_done) begin
      if (lo_r != '0) begin
        res_page_nxt = found_sum;
        res_sts_nxt  = STS_OK;
      end else begin
        res_page_nxt = '0;
        res_sts_nxt  = STS_NOT_FOUND;
      end
    end
    if (cmd.out_load) begin
      out_page_nxt = res_page_r;
      out_sts_nxt  = res_sts_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      last_r   <= '0;
      cursor_r <= '0;
      max_r    <= '0;
    end else begin
      cnt_r    <= cnt_nxt;
      last_r   <= last_nxt;
      cursor_r <= cursor_nxt;
      max_r    <= max_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sp_r       <= sp_nxt;
    first_r    <= first_nxt;
    q_r        <= q_nxt;
    lo_r       <= lo_nxt;
    hi_r       <= hi_nxt;
    diff_r     <= diff_nxt;
    cand_r     <= cand_nxt;
    res_page_r <= res_page_nxt;
    res_sts_r  <= res_sts_nxt;
    out_page_r <= out_page_nxt;
    out_sts_r  <= out_sts_nxt;
  end

  assign out_page_number = out_page_r;
  assign out_status      = out_sts_r;

endmodule

FILE: hw/rtl/rpem_checker.sv
// ----------------------------------------------------------------------------
// rpem_checker
// port-level checks on the relative page extent map, bound to the top level
// ----------------------------------------------------------------------------
`include "relative_page_extent_map_assert.svh"

module rpem_checker import rpem_pkg::*; (
  input logic              clk,
  input logic              rst_n,
  input logic              in_valid,
  input logic              in_ready,
  input logic              out_valid,
  input logic              out_ready,
  input logic [PAGE_W-1:0] out_page_number,
  input logic [1:0]        out_status
);

  // a stalled result holds
  `RPEM_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(out_page_number) && $stable(out_status))

  // failed requests carry a zero page
  `RPEM_ASSERT_NOW(a_err_zero, out_valid && (out_status != STS_OK), out_page_number == '0)

  // one request at a time
  `RPEM_ASSERT_NEXT(a_busy_after_req, in_valid && in_ready, !in_ready)

  // reset empties the result stage
  `RPEM_ASSERT_NEXT_ANY(a_reset_idle, !rst_n, !out_valid)

endmodule

bind relative_page_extent_map rpem_checker u_rpem_checker (.*);
